// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is high.
`define IAM_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define IAM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/iam_pkg.sv
// Package for the input action mapper: opcodes, states, control structs.
`timescale 1ns / 1ps
package iam_pkg;

  localparam int NUM_GROUPS = 3;
  localparam logic [8:0] UNKNOWN_CODE = 9'd511;
  localparam logic signed [15:0] HALF = 16'sd16384;
  localparam logic signed [15:0] NEG_HALF = -16'sd16384;
  localparam int SUM_W = 36;

  typedef enum logic [2:0] {
    OP_EVENT  = 3'd0,
    OP_TICK   = 3'd1,
    OP_BIND   = 3'd2,
    OP_BEGIN  = 3'd3,
    OP_CANCEL = 3'd4,
    OP_QUERY  = 3'd5
  } opcode_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_DECODE,
    S_EV_WR,
    S_RB_WR,
    S_BIND_WR,
    S_TICK_RD,
    S_TICK_WR,
    S_Q_SLOT,
    S_Q_LVL,
    S_Q_MUL,
    S_Q_ACC,
    S_Q_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic clr;
    logic tick_rd;
    logic tick_wr;
    logic ev_wr;
    logic rb_set;
    logic rb_clr;
    logic cnt_rd;
    logic cnt_pend;
    logic rb_wr;
    logic bind_wr;
    logic q_start;
    logic slot_rd;
    logic lvl_rd;
    logic mul;
    logic acc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    pend_hit;
    logic    ev_ok;
    logic    bind_ok;
    logic    tgt_ok;
    logic    begin_ok;
    logic    cnt_full;
    logic    slot_more;
    logic    out_busy;
    logic    clr_last;
    logic    tick_last;
  } stat_t;

endpackage

// File: hw/rtl/iam_ctrl.sv
// Controller state machine for the input action mapper.
`timescale 1ns / 1ps
module iam_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  iam_pkg::stat_t stat,
  output iam_pkg::cmd_t  cmd
);
  import iam_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR:  if (stat.clr_last) state_next = S_IDLE;
      S_IDLE: if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        case (stat.op)
          OP_EVENT: begin
            if (stat.pend_hit) state_next = S_RB_WR;
            else if (stat.ev_ok) state_next = S_EV_WR;
            else state_next = S_IDLE;
          end
          OP_TICK:  state_next = S_TICK_RD;
          OP_BIND:  state_next = stat.bind_ok ? S_BIND_WR : S_IDLE;
          OP_QUERY: state_next = stat.tgt_ok ? S_Q_SLOT : S_Q_DONE;
          default:  state_next = S_IDLE;
        endcase
      end
      S_EV_WR:   state_next = S_IDLE;
      S_RB_WR:   state_next = S_IDLE;
      S_BIND_WR: state_next = S_IDLE;
      S_TICK_RD: state_next = S_TICK_WR;
      S_TICK_WR: state_next = stat.tick_last ? S_IDLE : S_TICK_RD;
      S_Q_SLOT:  state_next = stat.slot_more ? S_Q_LVL : S_Q_DONE;
      S_Q_LVL:   state_next = S_Q_MUL;
      S_Q_MUL:   state_next = S_Q_ACC;
      S_Q_ACC:   state_next = S_Q_SLOT;
      S_Q_DONE:  if (!stat.out_busy) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = (state == S_IDLE);
    cmd.load = in_valid && in_ready;
    unique case (state)
      S_CLR: cmd.clr = 1'b1;
      S_DECODE: begin
        case (stat.op)
          OP_EVENT: begin
            cmd.cnt_rd   = stat.pend_hit;
            cmd.cnt_pend = 1'b1;
          end
          OP_BIND:   cmd.cnt_rd = stat.bind_ok;
          OP_BEGIN:  cmd.rb_set = stat.begin_ok;
          OP_CANCEL: cmd.rb_clr = 1'b1;
          OP_QUERY: begin
            cmd.q_start = 1'b1;
            cmd.cnt_rd  = stat.tgt_ok;
          end
          default: ;
        endcase
      end
      S_EV_WR:   cmd.ev_wr = 1'b1;
      S_RB_WR:   cmd.rb_wr = 1'b1;
      S_BIND_WR: cmd.bind_wr = !stat.cnt_full;
      S_TICK_RD: cmd.tick_rd = 1'b1;
      S_TICK_WR: cmd.tick_wr = 1'b1;
      S_Q_SLOT:  cmd.slot_rd = stat.slot_more;
      S_Q_LVL:   cmd.lvl_rd = 1'b1;
      S_Q_MUL:   cmd.mul = 1'b1;
      S_Q_ACC:   cmd.acc = 1'b1;
      S_Q_DONE:  cmd.out_load = !stat.out_busy;
      default: ;
    endcase
  end
endmodule

// File: hw/rtl/iam_datapath.sv
// Datapath: item latch, level and binding stores, query accumulator, output register.
`timescale 1ns / 1ps
module iam_datapath #(
  parameter int NUM_INPUTS        = 256,
  parameter int SLOTS_PER_ACTION  = 4,
  parameter int ACTIONS_PER_GROUP = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [2:0]         opcode,
  input  logic [1:0]         action_group,
  input  logic [4:0]         action_index,
  input  logic [8:0]         input_code,
  input  logic signed [15:0] input_level,
  input  logic signed [15:0] binding_scale,
  input  logic [1:0]         slot_number,
  input  iam_pkg::cmd_t      cmd,
  output iam_pkg::stat_t     stat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] action_value,
  output logic               pressed,
  output logic               held,
  output logic               released
);
  import iam_pkg::*;

  localparam int NA = NUM_GROUPS * ACTIONS_PER_GROUP;
  localparam int NT = NA * SLOTS_PER_ACTION;
  localparam int AW = $clog2(NA);
  localparam int TW = $clog2(NT);
  localparam int LW = $clog2(NUM_INPUTS);
  localparam int CW = $clog2(SLOTS_PER_ACTION + 1);
  localparam int CLR_N = (NUM_INPUTS > NA) ? NUM_INPUTS : NA;
  localparam int PW = $clog2(CLR_N);
  localparam logic signed [SUM_W-1:0] LIM = SUM_W'(64'sd134217728);

  // item latch
  logic [2:0]         op_q;
  logic [1:0]         grp_q;
  logic [4:0]         act_q;
  logic [8:0]         code_q;
  logic signed [15:0] lvl_q;
  logic signed [15:0] scl_q;
  logic [1:0]         slot_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= opcode;
      grp_q  <= action_group;
      act_q  <= action_index;
      code_q <= input_code;
      lvl_q  <= input_level;
      scl_q  <= binding_scale;
      slot_q <= slot_number;
    end
  end

  logic [AW-1:0] item_lin;
  assign item_lin = AW'(AW'(grp_q) * AW'(ACTIONS_PER_GROUP) + AW'(act_q));

  // pending rebind
  logic               rb_pend;
  logic [AW-1:0]      rb_act;
  logic [1:0]         rb_slot;
  logic signed [15:0] rb_wt;

  always_ff @(posedge clk) begin
    if (rst) rb_pend <= 1'b0;
    else if (cmd.rb_set) rb_pend <= 1'b1;
    else if (cmd.rb_clr || cmd.rb_wr) rb_pend <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rb_act  <= '0;
      rb_slot <= '0;
      rb_wt   <= '0;
    end else if (cmd.rb_set) begin
      rb_act  <= item_lin;
      rb_slot <= slot_q;
      rb_wt   <= scl_q;
    end
  end

  // sweep pointer for the clearing pass and the tick copy
  logic [PW-1:0] ptr;
  logic          clr_last, tick_last;

  assign clr_last  = (32'(ptr) == CLR_N - 1);
  assign tick_last = (32'(ptr) == NUM_INPUTS - 1);

  always_ff @(posedge clk) begin
    if (rst) ptr <= '0;
    else if ((cmd.clr && clr_last) || (cmd.tick_wr && tick_last)) ptr <= '0;
    else if (cmd.clr || cmd.tick_wr) ptr <= ptr + PW'(1);
  end

  // binding counts
  logic [CW-1:0] cnt_mem [NA];
  logic [CW-1:0] cnt_raw_q;
  logic [CW-1:0] cnt_val;
  logic [AW-1:0] cnt_addr;
  logic [AW-1:0] cnt_waddr;
  logic [CW-1:0] cnt_wdata;
  logic          cnt_we;

  assign cnt_addr  = cmd.cnt_pend ? rb_act : item_lin;
  assign cnt_val   = cnt_raw_q;
  assign cnt_we    = cmd.rb_wr || cmd.bind_wr || (cmd.clr && (32'(ptr) < NA));
  assign cnt_waddr = cmd.clr ? AW'(ptr) : (cmd.rb_wr ? rb_act : item_lin);
  assign cnt_wdata = cmd.clr ? '0 :
                     cmd.rb_wr ?
                     ((cnt_val <= CW'(rb_slot)) ? CW'(rb_slot) + CW'(1) : cnt_val) :
                     cnt_val + CW'(1);

  always_ff @(posedge clk) begin
    if (cmd.cnt_rd) cnt_raw_q <= cnt_mem[cnt_addr];
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
  end

  // binding table: code in [24:16], scale in [15:0]
  logic [24:0]   tbl_mem [NT];
  logic [24:0]   tbl_q;
  logic [CW-1:0] idx;
  logic [TW-1:0] tbl_waddr;
  logic [TW-1:0] tbl_raddr;
  logic [24:0]   tbl_wdata;

  assign tbl_waddr = cmd.rb_wr ?
                     TW'(TW'(rb_act) * TW'(SLOTS_PER_ACTION) + TW'(rb_slot)) :
                     TW'(TW'(item_lin) * TW'(SLOTS_PER_ACTION) + TW'(cnt_val));
  assign tbl_raddr = TW'(TW'(item_lin) * TW'(SLOTS_PER_ACTION) + TW'(idx));
  assign tbl_wdata = cmd.rb_wr ? {code_q, rb_wt} : {code_q, scl_q};

  always_ff @(posedge clk) begin
    if (cmd.rb_wr || cmd.bind_wr) tbl_mem[tbl_waddr] <= tbl_wdata;
    if (cmd.slot_rd) tbl_q <= tbl_mem[tbl_raddr];
  end

  // level stores; a tick copies current to previous one entry at a time
  logic [15:0]        cur_mem [NUM_INPUTS];
  logic [15:0]        prv_mem [NUM_INPUTS];
  logic [15:0]        cur_raw_q, prv_raw_q;
  logic               lvl_ok_q;
  logic [LW-1:0]      lvl_addr;
  logic [LW-1:0]      ev_addr;
  logic [LW-1:0]      swp_addr;
  logic [LW-1:0]      cur_waddr;
  logic [15:0]        cur_wdata;
  logic [15:0]        prv_wdata;
  logic               swp_in, cur_we, prv_we;
  logic signed [15:0] cur_val, prv_val;

  assign swp_addr  = LW'(ptr);
  assign swp_in    = 32'(ptr) < NUM_INPUTS;
  assign ev_addr   = code_q[LW-1:0];
  assign lvl_addr  = cmd.tick_rd ? swp_addr : tbl_q[16 +: LW];
  assign cur_val   = cur_raw_q;
  assign prv_val   = prv_raw_q;
  assign cur_we    = cmd.ev_wr || (cmd.clr && swp_in);
  assign cur_waddr = cmd.clr ? swp_addr : ev_addr;
  assign cur_wdata = cmd.clr ? '0 : lvl_q;
  assign prv_we    = (cmd.clr && swp_in) || cmd.tick_wr;
  assign prv_wdata = cmd.clr ? '0 : cur_raw_q;

  always_ff @(posedge clk) begin
    if (cmd.lvl_rd || cmd.tick_rd) begin
      cur_raw_q <= cur_mem[lvl_addr];
      prv_raw_q <= prv_mem[lvl_addr];
    end
    if (cmd.lvl_rd) lvl_ok_q <= (32'(tbl_q[24:16]) < NUM_INPUTS);
    if (cur_we) cur_mem[cur_waddr] <= cur_wdata;
    if (prv_we) prv_mem[swp_addr] <= prv_wdata;
  end

  // query accumulation
  logic signed [31:0]      prod_q;
  logic                    p_q, r_q, p_acc, r_acc;
  logic signed [SUM_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_q <= lvl_ok_q ? cur_val * $signed(tbl_q[15:0]) : 32'sd0;
      p_q    <= lvl_ok_q && (cur_val > HALF) && (prv_val <= HALF);
      r_q    <= lvl_ok_q && (cur_val <= HALF) && (prv_val > HALF);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_start) begin
      sum   <= '0;
      idx   <= '0;
      p_acc <= 1'b0;
      r_acc <= 1'b0;
    end else if (cmd.acc) begin
      sum   <= sum + {{(SUM_W-32){prod_q[31]}}, prod_q};
      idx   <= idx + CW'(1);
      p_acc <= p_acc | p_q;
      r_acc <= r_acc | r_q;
    end
  end

  // clamp and round toward minus infinity
  logic signed [15:0] val;
  always_comb begin
    if (sum >= LIM) val = 16'sd32767;
    else if (sum <= -LIM) val = -16'sd32768;
    else val = sum[27:12];
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      action_value <= val;
      pressed      <= p_acc;
      released     <= r_acc;
      held         <= (val > HALF) || (val < NEG_HALF);
    end
  end

  // status
  logic tgt_ok;
  assign tgt_ok = (grp_q < 2'(NUM_GROUPS)) && (32'(act_q) < ACTIONS_PER_GROUP);

  assign stat.op        = opcode_t'(op_q);
  assign stat.pend_hit  = rb_pend && ((lvl_q > HALF) || (lvl_q < NEG_HALF));
  assign stat.ev_ok     = 32'(code_q) < NUM_INPUTS;
  assign stat.bind_ok   = tgt_ok && (code_q != UNKNOWN_CODE);
  assign stat.tgt_ok    = tgt_ok;
  assign stat.begin_ok  = tgt_ok && (32'(slot_q) < SLOTS_PER_ACTION);
  assign stat.cnt_full  = 32'(cnt_val) >= SLOTS_PER_ACTION;
  assign stat.slot_more = idx < cnt_val;
  assign stat.out_busy  = out_valid && !out_ready;
  assign stat.clr_last  = clr_last;
  assign stat.tick_last = tick_last;
endmodule

// File: hw/rtl/input_action_mapper.sv
// Top level of the input action mapper: controller plus datapath.
`timescale 1ns / 1ps
// Maps input levels to actions through a per-action binding table. After reset a
// clearing pass zeroes the level and count stores while in_ready stays low. Then
// one item at a time: a cancel, begin-rebind, unused opcode, dropped input event
// or bind with an invalid target or unknown code ends after its decode state; a
// stored input event or a rebind completion passes through a write state, as does
// a bind with a valid target and known code, which is stored only while a slot is
// free; a tick copies each current level to its previous level through one read
// and one write; a query, after its slots, waits in its done state for any
// earlier result still held by out_ready. The query walks its slots one at a time
// through the single read port of the binding and level memories and the one
// multiplier. The next item may be accepted while a query result waits in the
// output register.
module input_action_mapper #(
  parameter int NUM_INPUTS        = 256,
  parameter int SLOTS_PER_ACTION  = 4,
  parameter int ACTIONS_PER_GROUP = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         opcode,
  input  logic [1:0]         action_group,
  input  logic [4:0]         action_index,
  input  logic [8:0]         input_code,
  input  logic signed [15:0] input_level,
  input  logic signed [15:0] binding_scale,
  input  logic [1:0]         slot_number,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] action_value,
  output logic               pressed,
  output logic               held,
  output logic               released
);
  import iam_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  iam_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  iam_datapath #(
    .NUM_INPUTS        (NUM_INPUTS),
    .SLOTS_PER_ACTION  (SLOTS_PER_ACTION),
    .ACTIONS_PER_GROUP (ACTIONS_PER_GROUP)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .opcode        (opcode),
    .action_group  (action_group),
    .action_index  (action_index),
    .input_code    (input_code),
    .input_level   (input_level),
    .binding_scale (binding_scale),
    .slot_number   (slot_number),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .action_value  (action_value),
    .pressed       (pressed),
    .held          (held),
    .released      (released)
  );
endmodule

// File: hw/rtl/iam_checker.sv
// Port-level checks for the input action mapper, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module iam_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] action_value,
  input logic               held
);
  `IAM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(action_value), "result changed while stalled")
  `IAM_ASSERT_CLK(a_held, !out_valid || (held == ((action_value > 16'sd16384) || (action_value < -16'sd16384))), "held disagrees with value")
  `IAM_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")
endmodule

bind input_action_mapper iam_checker u_iam_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .action_value (action_value),
  .held         (held)
);

// File: tb/input_action_mapper_tb.sv
// Self-checking testbench for the input action mapper: random stimulus, predictor, scoreboard.
`timescale 1ns / 1ps
module input_action_mapper_tb;
  import iam_pkg::*;

  localparam int N_CODES = 256;
  localparam int N_SLOTS = 4;
  localparam int N_ACTS = 32;
  localparam int N_RANDOM = 1800;
  localparam int STALL_LIMIT = 4000;
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam logic [1:0] NO_PENDING = 2'd3;

  typedef struct {
    logic [2:0] op;
    logic [1:0] grp;
    logic [4:0] act;
    logic [8:0] code;
    logic signed [15:0] lvl;
    logic signed [15:0] scale;
    logic [1:0] slot;
  } cmd_item_t;

  typedef struct {
    logic signed [15:0] value;
    logic pressed;
    logic held;
    logic released;
  } action_resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] opcode = '0;
  logic [1:0] action_group = '0;
  logic [4:0] action_index = '0;
  logic [8:0] input_code = '0;
  logic signed [15:0] input_level = '0;
  logic signed [15:0] binding_scale = '0;
  logic [1:0] slot_number = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] action_value;
  logic pressed, held, released;

  input_action_mapper uut (.*);

  // predictor state
  logic signed [15:0] cur_lvl [N_CODES];
  logic signed [15:0] prev_lvl [N_CODES];
  logic [8:0] bind_code [3][N_ACTS][N_SLOTS];
  logic signed [15:0] bind_scale [3][N_ACTS][N_SLOTS];
  int bind_cnt [3][N_ACTS];
  logic [1:0] rb_grp;
  logic [4:0] rb_act;
  logic [1:0] rb_slot;
  logic signed [15:0] rb_weight;

  cmd_item_t cmd_q[$];
  action_resp_t resp_q[$];
  int errors = 0;
  int n_cmds = 0;
  int n_resps = 0;
  int n_rebinds = 0;
  bit quiet = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic action_resp_t eval_action(logic [1:0] g, logic [4:0] a);
    action_resp_t r;
    longint sum;
    logic signed [15:0] c, p;
    r = '{default: 0};
    sum = 0;
    if (g == NO_PENDING) return r;
    for (int i = 0; i < bind_cnt[g][a]; i++) begin
      if (bind_code[g][a][i] < N_CODES) begin
        c = cur_lvl[bind_code[g][a][i]];
        p = prev_lvl[bind_code[g][a][i]];
        sum += longint'(c) * longint'(bind_scale[g][a][i]);
        if (c > HALF && p <= HALF) r.pressed = 1'b1;
        if (c <= HALF && p > HALF) r.released = 1'b1;
      end
    end
    if (sum >= (longint'(32768) <<< 12)) r.value = 16'sd32767;
    else if (sum <= -(longint'(32768) <<< 12)) r.value = -16'sd32768;
    else r.value = 16'(sum >>> 12);
    r.held = (r.value > HALF) || (r.value < NEG_HALF);
    return r;
  endfunction

  // Update the predictor and queue the item for the driver.
  task automatic issue(cmd_item_t it);
    n_cmds++;
    case (it.op)
      OP_EVENT: begin
        if (rb_grp != NO_PENDING && (it.lvl > HALF || it.lvl < NEG_HALF)) begin
          bind_code[rb_grp][rb_act][rb_slot] = it.code;
          bind_scale[rb_grp][rb_act][rb_slot] = rb_weight;
          if (bind_cnt[rb_grp][rb_act] <= rb_slot) bind_cnt[rb_grp][rb_act] = rb_slot + 1;
          rb_grp = NO_PENDING;
          n_rebinds++;
        end else if (it.code < N_CODES) begin
          cur_lvl[it.code] = it.lvl;
        end
      end
      OP_TICK: prev_lvl = cur_lvl;
      OP_BIND: begin
        if (it.code != UNKNOWN_CODE && it.grp != NO_PENDING && bind_cnt[it.grp][it.act] < N_SLOTS) begin
          bind_code[it.grp][it.act][bind_cnt[it.grp][it.act]] = it.code;
          bind_scale[it.grp][it.act][bind_cnt[it.grp][it.act]] = it.scale;
          bind_cnt[it.grp][it.act]++;
        end
      end
      OP_BEGIN: begin
        if (it.grp != NO_PENDING) begin
          rb_grp = it.grp;
          rb_act = it.act;
          rb_slot = it.slot;
          rb_weight = it.scale;
        end
      end
      OP_CANCEL: rb_grp = NO_PENDING;
      OP_QUERY: resp_q.push_back(eval_action(it.grp, it.act));
      default: ;
    endcase
    cmd_q.push_back(it);
  endtask

  function automatic cmd_item_t mk(logic [2:0] op, logic [1:0] g, logic [4:0] a,
                                   logic [8:0] code, int lvl, int scale, logic [1:0] slot);
    cmd_item_t it;
    it.op = op; it.grp = g; it.act = a; it.code = code;
    it.lvl = 16'(lvl); it.scale = 16'(scale); it.slot = slot;
    return it;
  endfunction

  function automatic logic [8:0] pick_code();
    if ($urandom_range(0, 99) < 85) return 9'($urandom_range(0, 15));
    return 9'($urandom_range(0, 511));
  endfunction

  function automatic logic signed [15:0] pick_level();
    case ($urandom_range(0, 11))
      0: return 16'sd32767;
      1: return -16'sd32768;
      2: return HALF;
      3: return HALF + 16'sd1;
      4: return NEG_HALF;
      5: return NEG_HALF - 16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [4:0] pick_act();
    if ($urandom_range(0, 9) < 7) return 5'($urandom_range(0, 3));
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [1:0] pick_grp();
    if ($urandom_range(0, 19) == 0) return NO_PENDING;
    return 2'($urandom_range(0, 2));
  endfunction

  // Rebind slot never beyond the written range, so no query reads an unwritten slot.
  task automatic rebind_seq();
    logic [1:0] g;
    logic [4:0] a;
    int top;
    g = 2'($urandom_range(0, 2));
    a = pick_act();
    top = (bind_cnt[g][a] < N_SLOTS - 1) ? bind_cnt[g][a] : N_SLOTS - 1;
    issue(mk(OP_BEGIN, g, a, pick_code(), $urandom, $urandom_range(0, 8191) - 4096,
             2'($urandom_range(0, top))));
    if ($urandom_range(0, 3) == 0)
      issue(mk(OP_EVENT, 0, 0, pick_code(), $urandom_range(0, 32768) - 16384, 0, 0));
    if ($urandom_range(0, 7) == 0) issue(mk(OP_CANCEL, 0, 0, 0, 0, 0, 0));
    issue(mk(OP_EVENT, 0, 0, pick_code(), $urandom_range(0, 1) ? 32767 : -32768, 0, 0));
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) issue(mk(OP_EVENT, 2'($urandom), 5'($urandom), pick_code(), pick_level(),
                         $urandom, 2'($urandom)));
    else if (r < 45) issue(mk(OP_TICK, 2'($urandom), 5'($urandom), 9'($urandom), $urandom,
                              $urandom, 2'($urandom)));
    else if (r < 57) issue(mk(OP_BIND, pick_grp(), pick_act(),
                              ($urandom_range(0, 19) == 0) ? UNKNOWN_CODE : pick_code(),
                              $urandom, ($urandom_range(0, 3) == 0) ? $urandom
                              : $urandom_range(0, 8191) - 4096, 2'($urandom)));
    else if (r < 63) rebind_seq();
    else if (r < 66) issue(mk(OP_CANCEL, 2'($urandom), 5'($urandom), 9'($urandom), $urandom,
                              $urandom, 2'($urandom)));
    else if (r < 98) issue(mk(OP_QUERY, pick_grp(), pick_act(), 9'($urandom), $urandom,
                              $urandom, 2'($urandom)));
    else issue(mk(r[0] ? OP_SPARE_A : OP_SPARE_B, 2'($urandom), 5'($urandom), 9'($urandom),
                  $urandom, $urandom, 2'($urandom)));
  endtask

  // Driver
  int in_gap = 0;
  always @(posedge clk) begin
    cmd_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        it = cmd_q.pop_front();
        opcode <= it.op;
        action_group <= it.grp;
        action_index <= it.act;
        input_code <= it.code;
        input_level <= it.lvl;
        binding_scale <= it.scale;
        slot_number <= it.slot;
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) in_gap <= $urandom_range(1, 6);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor and scoreboard
  int out_gap = 0;
  always @(posedge clk) begin
    action_resp_t e;
    if (!rst && out_valid && out_ready) begin
      n_resps++;
      if (resp_q.size() == 0) begin
        $error("unexpected result: action_value %0d", action_value);
        errors++;
      end else begin
        e = resp_q.pop_front();
        if (action_value !== e.value) begin
          $error("action_value: expected %0d, got %0d", e.value, action_value); errors++;
        end
        if (pressed !== e.pressed) begin
          $error("pressed: expected %0b, got %0b", e.pressed, pressed); errors++;
        end
        if (held !== e.held) begin
          $error("held: expected %0b, got %0b", e.held, held); errors++;
        end
        if (released !== e.released) begin
          $error("released: expected %0b, got %0b", e.released, released); errors++;
        end
      end
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 9) == 0) out_gap <= $urandom_range(1, 6);
    end
  end

  // Watchdog
  int stall = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall <= 0;
    else if (cmd_q.size() > 0 || resp_q.size() > 0 || in_valid) begin
      if (stall >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
      stall <= stall + 1;
    end
  end

  task automatic drain();
    while (cmd_q.size() > 0 || in_valid || resp_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < N_CODES; i++) begin
      cur_lvl[i] = '0;
      prev_lvl[i] = '0;
    end
    foreach (bind_cnt[g, a]) bind_cnt[g][a] = 0;
    rb_grp = NO_PENDING; rb_act = '0; rb_slot = '0; rb_weight = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed
    issue(mk(OP_QUERY, 0, 0, 0, 0, 0, 0));
    issue(mk(OP_BIND, 0, 0, 1, 0, 32767, 0));
    issue(mk(OP_BIND, 0, 0, 2, 0, -32768, 0));
    issue(mk(OP_BIND, 0, 0, UNKNOWN_CODE, 0, 4096, 0));
    issue(mk(OP_BIND, NO_PENDING, 0, 3, 0, 4096, 0));
    issue(mk(OP_EVENT, 0, 0, 1, 32767, 0, 0));
    issue(mk(OP_EVENT, 0, 0, 2, -32768, 0, 0));
    issue(mk(OP_QUERY, 0, 0, 0, 0, 0, 0));
    issue(mk(OP_TICK, 0, 0, 0, 0, 0, 0));
    issue(mk(OP_EVENT, 0, 0, 1, 16384, 0, 0));
    issue(mk(OP_QUERY, 0, 0, 0, 0, 0, 0));
    issue(mk(OP_TICK, 0, 0, 0, 0, 0, 0));
    issue(mk(OP_EVENT, 0, 0, 1, 16385, 0, 0));
    issue(mk(OP_EVENT, 0, 0, 300, 100, 0, 0));
    issue(mk(OP_BIND, 0, 0, 300, 0, 4096, 0));
    issue(mk(OP_BIND, 0, 0, 5, 0, 4096, 0));
    issue(mk(OP_BIND, 0, 0, 6, 0, 4096, 0));
    issue(mk(OP_QUERY, 0, 0, 0, 0, 0, 0));
    issue(mk(OP_BEGIN, 0, 1, 0, 0, 4096, 0));
    issue(mk(OP_EVENT, 0, 0, 7, 16384, 0, 0));
    issue(mk(OP_EVENT, 0, 0, 7, -16385, 0, 0));
    issue(mk(OP_QUERY, 0, 1, 0, 0, 0, 0));
    issue(mk(OP_BEGIN, 1, 2, 0, 0, 4096, 0));
    issue(mk(OP_CANCEL, 0, 0, 0, 0, 0, 0));
    issue(mk(OP_EVENT, 0, 0, 8, 32767, 0, 0));
    issue(mk(OP_BEGIN, 2, 31, 0, 0, -32768, 0));
    issue(mk(OP_EVENT, 0, 0, UNKNOWN_CODE, -32768, 0, 0));
    issue(mk(OP_QUERY, 2, 31, 0, 0, 0, 0));
    issue(mk(OP_QUERY, NO_PENDING, 0, 0, 0, 0, 0));
    issue(mk(OP_SPARE_A, 0, 0, 0, 0, 0, 0));
    issue(mk(OP_SPARE_B, 0, 0, 0, 0, 0, 0));

    for (int i = 0; i < N_RANDOM; i++) begin
      while (cmd_q.size() > 8) @(posedge clk);
      if (i == N_RANDOM / 2) drain();
      if (i == N_RANDOM - 300) quiet = 1'b1;
      random_item();
    end
    drain();
    repeat (40) @(posedge clk);
    $display("%0d items sent, %0d query results checked, %0d rebinds completed",
             n_cmds, n_resps, n_rebinds);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// File: input_action_mapper.f
+incdir+hw/rtl
hw/rtl/iam_pkg.sv
hw/rtl/iam_ctrl.sv
hw/rtl/iam_datapath.sv
hw/rtl/input_action_mapper.sv
hw/rtl/iam_checker.sv
tb/input_action_mapper_tb.sv
